### sv/jesc_pkg.sv
package jesc_pkg;

  // coordinate and product widths of the iteration datapath
  localparam int unsigned CoordW = 24;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned FracW  = 16;

  // escape bound: 64.0 in Q.32
  localparam logic signed [SumW-1:0] ESC_LIMIT = 49'sd274877906944;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_C_REAL,
    REG_C_IMAG,
    REG_RED_OFS,
    REG_GREEN_OFS,
    REG_BLUE_OFS
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AA,
    ST_BB,
    ST_AB,
    ST_DONE
  } iter_state_t;

  // configuration register contents
  typedef struct packed {
    logic signed [17:0] c_real;
    logic signed [17:0] c_imag;
    logic [5:0]         red_ofs;
    logic [5:0]         green_ofs;
    logic [5:0]         blue_ofs;
  } jesc_cfg_t;

  // finished pixel from the sequencer
  typedef struct packed {
    logic       valid;
    logic [7:0] count;
    logic       bounded;
  } jesc_res_t;

endpackage

### sv/jesc_cfg.sv
module jesc_cfg import jesc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output jesc_cfg_t   cfg
);

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_real    <= 18'sd65536;
      cfg.c_imag    <= 18'sd0;
      cfg.red_ofs   <= 6'd0;
      cfg.green_ofs <= 6'd0;
      cfg.blue_ofs  <= 6'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_C_REAL:    cfg.c_real    <= $signed(cfg_data);
        REG_C_IMAG:    cfg.c_imag    <= $signed(cfg_data);
        REG_RED_OFS:   cfg.red_ofs   <= cfg_data[5:0];
        REG_GREEN_OFS: cfg.green_ofs <= cfg_data[5:0];
        REG_BLUE_OFS:  cfg.blue_ofs  <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/jesc_mul.sv
module jesc_mul import jesc_pkg::*; (
  input  logic                     clk,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  output logic signed [ProdW-1:0]  p
);

  // shared signed multiplier with registered product
  always_ff @(posedge clk) begin
    p <= x * y;
  end

endmodule

### sv/jesc_iter.sv
module jesc_iter import jesc_pkg::*; #(
  parameter int unsigned MAX_ITER = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  jesc_cfg_t          cfg,
  input  logic               start_valid,
  output logic               start_ready,
  input  logic signed [18:0] start_real,
  input  logic signed [20:0] start_imag,
  output jesc_res_t          res,
  input  logic               res_take
);

  iter_state_t state, state_next;

  logic signed [CoordW-1:0] a;
  logic signed [CoordW-1:0] b;
  logic signed [ProdW-1:0]  aa;
  logic [7:0]               n;
  logic                     bounded;

  logic signed [CoordW-1:0] mul_x;
  logic signed [CoordW-1:0] mul_y;
  logic signed [ProdW-1:0]  p;

  logic signed [SumW-1:0]   mag;
  logic signed [SumW-1:0]   diff;
  logic signed [SumW-1:0]   a_sum;
  logic signed [ProdW-1:0]  b_sum;
  logic                     escape;
  logic [7:0]               n_inc;
  logic                     last_iter;

  // operand select for the shared multiplier
  always_comb begin
    mul_x = a;
    mul_y = b;
    unique case (state)
      ST_AA: begin
        mul_x = a;
        mul_y = a;
      end
      ST_BB: begin
        mul_x = b;
        mul_y = b;
      end
      default: begin
        mul_x = a;
        mul_y = b;
      end
    endcase
  end

  jesc_mul u_mul (
    .clk (clk),
    .x   (mul_x),
    .y   (mul_y),
    .p   (p)
  );

  // escape test and update: in ST_AB the product holds b*b, in ST_AA it holds a*b
  assign mag    = $signed({aa[ProdW-1], aa}) + $signed({p[ProdW-1], p});
  assign diff   = $signed({aa[ProdW-1], aa}) - $signed({p[ProdW-1], p});
  assign escape = mag > ESC_LIMIT;
  assign a_sum  = (diff >>> FracW) + $signed({{(SumW-18){cfg.c_real[17]}}, cfg.c_real});
  assign b_sum  = (p >>> (FracW - 1)) + $signed({{(ProdW-18){cfg.c_imag[17]}}, cfg.c_imag});
  assign n_inc  = n + 8'd1;
  assign last_iter = (n_inc == 8'(MAX_ITER));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start_valid) state_next = ST_AA;
      ST_AA:   state_next = ST_BB;
      ST_BB:   state_next = ST_AB;
      ST_AB: begin
        if (escape || last_iter) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_AA;
        end
      end
      ST_DONE: if (res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start_valid) begin
          a <= CoordW'(start_real);
          b <= CoordW'(start_imag);
          n <= 8'd0;
        end
      end
      ST_AA: begin
        // the pending imaginary update from the previous pass
        if (n != 8'd0) b <= b_sum[CoordW-1:0];
      end
      ST_BB: aa <= p;
      ST_AB: begin
        if (escape) begin
          bounded <= 1'b0;
        end else begin
          a       <= a_sum[CoordW-1:0];
          n       <= n_inc;
          bounded <= last_iter;
        end
      end
      default: begin
      end
    endcase
  end

  assign start_ready = (state == ST_IDLE);
  assign res.valid   = (state == ST_DONE);
  assign res.count   = n;
  assign res.bounded = bounded;

endmodule

### sv/julia_escape_time_pixel_unit.sv
// channel   | dir | handshake           | payload
// s_axis    | in  | s_tvalid / s_tready | s_tdata: start_real, start_imag
// m_axis    | out | m_tvalid / m_tready | m_tdata: iterations, stayed_bounded, red, green, blue
// cfg       | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// each iteration is three passes through the single shared multiplier
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next pixel may be accepted meanwhile
// reset is synchronous and restores the configuration register values
module julia_escape_time_pixel_unit import jesc_pkg::*; #(
  parameter int unsigned MAX_ITER = 200
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // start_real[18:0], start_imag[39:19]
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // iterations[7:0], stayed_bounded[8], red[16:9],
                                 // green[24:17], blue[32:25], zero[39:33]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  jesc_cfg_t cfg;
  jesc_res_t res;
  logic      res_take;

  logic [7:0] out_count;
  logic       out_bounded;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] chan_base;
  logic [8:0] red_sum;
  logic [8:0] green_sum;
  logic [8:0] blue_sum;

  assign cfg_ready = 1'b1;

  jesc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jesc_iter #(
    .MAX_ITER (MAX_ITER)
  ) u_iter (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start_valid (s_tvalid),
    .start_ready (s_tready),
    .start_real  ($signed(s_tdata[18:0])),
    .start_imag  ($signed(s_tdata[39:19])),
    .res         (res),
    .res_take    (res_take)
  );

  // colour channels with saturation at 255
  assign chan_base = res.bounded ? 8'd0 : res.count;
  assign red_sum   = {1'b0, chan_base} + {3'd0, cfg.red_ofs};
  assign green_sum = {1'b0, chan_base} + {3'd0, cfg.green_ofs};
  assign blue_sum  = {1'b0, chan_base} + {3'd0, cfg.blue_ofs};

  assign res_take = res.valid && (!m_tvalid || m_tready);

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_count   <= res.count;
      out_bounded <= res.bounded;
      out_red     <= red_sum[8]   ? 8'd255 : red_sum[7:0];
      out_green   <= green_sum[8] ? 8'd255 : green_sum[7:0];
      out_blue    <= blue_sum[8]  ? 8'd255 : blue_sum[7:0];
    end
  end

  assign m_tdata = {7'd0, out_blue, out_green, out_red, out_bounded, out_count};

  // a bounded point always reports the full iteration limit
  a_bounded_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'(MAX_ITER)))
    else $error("bounded result without full iteration count");

  // an escaped point stops short of the limit
  a_escaped_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] < 8'(MAX_ITER)))
    else $error("escaped result at or beyond iteration limit");

  // the sequencer is busy right after taking a pixel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after an input transaction");

  // a result is never handed over while the sequencer is idle
  a_take_only_done: assert property (@(posedge clk) disable iff (rst)
    res_take |-> !s_tready)
    else $error("result taken while sequencer idle");

endmodule
